/* hw/rtl/quaternion_vector_rotate_top_defines.svh */
// ----------------------------------------------------------------------------
// Quaternion vector rotate assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define QVR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("qvr: assertion failed");
// prop must never hold outside reset
`define QVR_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("qvr: forbidden condition seen");
`else
`define QVR_ASSERT(lbl, clk, rst_n, prop)
`define QVR_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

/* hw/rtl/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate package
// Widths, latencies, register codes and request/result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int unsigned VEC_WIDTH  = 24;
  localparam int unsigned QUAT_WIDTH = 16;
  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned NUM_REGS   = 4;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned ADDR_W     = $clog2(4 * NUM_REGS);

  // square of a quaternion component, always non-negative
  localparam int unsigned SQ_W   = 2 * QUAT_WIDTH - 1;
  localparam int unsigned UU_W   = 2 * QUAT_WIDTH;
  localparam int unsigned DEN_W  = 2 * QUAT_WIDTH + 1;
  localparam int unsigned S_W    = 2 * QUAT_WIDTH + 1;
  localparam int unsigned PROD_W = QUAT_WIDTH + VEC_WIDTH;
  localparam int unsigned CRS_W  = PROD_W + 1;
  localparam int unsigned DOT_W  = PROD_W + 2;
  localparam int unsigned W2_W   = QUAT_WIDTH + 1;
  localparam int unsigned NUM_W  = 2 * QUAT_WIDTH + VEC_WIDTH + 2;
  localparam int unsigned TOP_W  = NUM_W - VEC_WIDTH;
  localparam int unsigned MAG_W  = VEC_WIDTH + 1;

  // pipeline depth: front end, lane (mult, sum, abs, range, one bit per stage, round)
  localparam int unsigned FRONT_LAT = 2;
  localparam int unsigned LANE_LAT  = VEC_WIDTH + 5;
  localparam int unsigned PIPE_LAT  = FRONT_LAT + LANE_LAT;
  localparam int unsigned RES_LAT   = PIPE_LAT + 1;

  localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);
  localparam logic [SQ_W-1:0]       WW_RST   = SQ_W'(1) << (2 * QUAT_WIDTH - 4);
  localparam logic [MAG_W-1:0]      HALF     = MAG_W'(1) << (VEC_WIDTH - 1);

  localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_QUAT_W,
    REG_QUAT_X,
    REG_QUAT_Y,
    REG_QUAT_Z
  } reg_idx_e;

  typedef struct packed {
    logic                        func;
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;
  } vec_req_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        saturated;
    logic                        zero_norm;
  } vec_res_t;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [S_W-1:0] s;
    logic [DEN_W-1:0]      den;
    logic                  zero;
  } norm_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             ovf;
  } lane_res_t;

  localparam quat_t QUAT_RST = '{w: QUAT_ONE, x: '0, y: '0, z: '0};
  localparam norm_t NORM_RST = '{s: S_W'(WW_RST), den: DEN_W'(WW_RST), zero: 1'b0};

endpackage

/* hw/rtl/qvr_norm.sv */
// ----------------------------------------------------------------------------
// Quaternion norm terms
// Registers w^2 - |u|^2, |q|^2 and the zero-norm flag from the quaternion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qvr_pkg::quat_t quat_i,
  output qvr_pkg::norm_t norm_o
);
  import qvr_pkg::*;

  logic signed [2*QUAT_WIDTH-1:0] sq_w, sq_x, sq_y, sq_z;
  logic [SQ_W-1:0] ww_d, ww_q;
  logic [UU_W-1:0] uu_d, uu_q;
  norm_t           norm_d, norm_q;

  always_comb begin
    sq_w = quat_i.w * quat_i.w;
    sq_x = quat_i.x * quat_i.x;
    sq_y = quat_i.y * quat_i.y;
    sq_z = quat_i.z * quat_i.z;
    ww_d = sq_w[SQ_W-1:0];
    uu_d = UU_W'(sq_x[SQ_W-1:0]) + UU_W'(sq_y[SQ_W-1:0]) + UU_W'(sq_z[SQ_W-1:0]);
  end

  always_comb begin
    norm_d.den  = DEN_W'(ww_q) + DEN_W'(uu_q);
    norm_d.s    = $signed(DEN_W'(ww_q)) - $signed(DEN_W'(uu_q));
    norm_d.zero = (quat_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q   <= WW_RST;
      uu_q   <= '0;
      norm_q <= NORM_RST;
    end else begin
      ww_q   <= ww_d;
      uu_q   <= uu_d;
      norm_q <= norm_d;
    end
  end

  assign norm_o = norm_q;

endmodule

/* hw/rtl/qvr_front.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate front end
// Component products, then doubled dot product and cross product u x v (negated for unrotate).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_front (
  input  logic                                   clk_i,
  input  qvr_pkg::vec_req_t                      req_i,
  input  qvr_pkg::quat_t                         quat_i,
  output logic signed [qvr_pkg::DOT_W-1:0]       dot2_o,
  output logic signed [qvr_pkg::CRS_W-1:0]       crs_o [qvr_pkg::NUM_LANES],
  output logic signed [qvr_pkg::VEC_WIDTH-1:0]   vec_o [qvr_pkg::NUM_LANES]
);
  import qvr_pkg::*;

  logic signed [PROD_W-1:0]    p_xx_q, p_yy_q, p_zz_q;
  logic signed [PROD_W-1:0]    p_yz_q, p_zy_q, p_zx_q, p_xz_q, p_xy_q, p_yx_q;
  logic                        func_q;
  logic signed [VEC_WIDTH-1:0] v1_q [NUM_LANES];
  logic signed [VEC_WIDTH-1:0] v2_q [NUM_LANES];
  logic signed [DOT_W-1:0]     dot_sum, dot2_d, dot2_q;
  logic signed [CRS_W-1:0]     crs_d [NUM_LANES];
  logic signed [CRS_W-1:0]     crs_q [NUM_LANES];

  always_ff @(posedge clk_i) begin
    p_xx_q  <= quat_i.x * req_i.vec_x;
    p_yy_q  <= quat_i.y * req_i.vec_y;
    p_zz_q  <= quat_i.z * req_i.vec_z;
    p_yz_q  <= quat_i.y * req_i.vec_z;
    p_zy_q  <= quat_i.z * req_i.vec_y;
    p_zx_q  <= quat_i.z * req_i.vec_x;
    p_xz_q  <= quat_i.x * req_i.vec_z;
    p_xy_q  <= quat_i.x * req_i.vec_y;
    p_yx_q  <= quat_i.y * req_i.vec_x;
    func_q  <= req_i.func;
    v1_q[0] <= req_i.vec_x;
    v1_q[1] <= req_i.vec_y;
    v1_q[2] <= req_i.vec_z;
  end

  // unrotate negates u: the dot term keeps its sign, the cross term flips
  always_comb begin
    dot_sum = DOT_W'(p_xx_q) + DOT_W'(p_yy_q) + DOT_W'(p_zz_q);
    dot2_d  = dot_sum <<< 1;
    if (func_q) begin
      crs_d[0] = CRS_W'(p_zy_q) - CRS_W'(p_yz_q);
      crs_d[1] = CRS_W'(p_xz_q) - CRS_W'(p_zx_q);
      crs_d[2] = CRS_W'(p_yx_q) - CRS_W'(p_xy_q);
    end else begin
      crs_d[0] = CRS_W'(p_yz_q) - CRS_W'(p_zy_q);
      crs_d[1] = CRS_W'(p_zx_q) - CRS_W'(p_xz_q);
      crs_d[2] = CRS_W'(p_xy_q) - CRS_W'(p_yx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    dot2_q <= dot2_d;
    crs_q  <= crs_d;
    v2_q   <= v1_q;
  end

  assign dot2_o = dot2_q;
  assign crs_o  = crs_q;
  assign vec_o  = v2_q;

endmodule

/* hw/rtl/qvr_lane.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate lane
// Numerator of one output component, then a restoring divider by |q|^2
// with one quotient bit per stage and round to nearest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_lane (
  input  logic                                  clk_i,
  input  logic signed [qvr_pkg::S_W-1:0]        s_i,
  input  logic [qvr_pkg::DEN_W-1:0]             den_i,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] w_i,
  input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] u_i,
  input  logic signed [qvr_pkg::DOT_W-1:0]      dot2_i,
  input  logic signed [qvr_pkg::CRS_W-1:0]      crs_i,
  input  logic signed [qvr_pkg::VEC_WIDTH-1:0]  vec_i,
  output qvr_pkg::lane_res_t                    res_o
);
  import qvr_pkg::*;

  logic signed [W2_W-1:0]  w2;
  logic signed [NUM_W-1:0] ps_q, pd_q, pc_q, num_q;
  logic [NUM_W-1:0]        mag_q;
  logic                    neg_q;
  logic [TOP_W-1:0]        top;
  logic                    top_ovf;

  logic [DEN_W-1:0]     rem_q [VEC_WIDTH+1];
  logic [VEC_WIDTH-1:0] lo_q  [VEC_WIDTH];
  logic [VEC_WIDTH-1:0] quo_q [VEC_WIDTH+1];
  logic                 sgn_q [VEC_WIDTH+1];
  logic                 ovf_q [VEC_WIDTH+1];

  logic      rnd;
  lane_res_t res_d, res_q;

  assign w2 = {w_i, 1'b0};

  // numerator: s*v + 2(u.v)*u + 2w*(u x v)
  always_ff @(posedge clk_i) begin
    ps_q  <= s_i * vec_i;
    pd_q  <= dot2_i * u_i;
    pc_q  <= w2 * crs_i;
    num_q <= ps_q + pd_q + pc_q;
    neg_q <= num_q[NUM_W-1];
    mag_q <= num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  end

  // quotient of 2^VEC_WIDTH or more always clips
  assign top     = mag_q[NUM_W-1 -: TOP_W];
  assign top_ovf = top >= TOP_W'(den_i);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= top[DEN_W-1:0];
    lo_q[0]  <= mag_q[VEC_WIDTH-1:0];
    quo_q[0] <= '0;
    sgn_q[0] <= neg_q;
    ovf_q[0] <= top_ovf;
  end

  for (genvar k = 0; k < VEC_WIDTH; k++) begin : g_div
    logic [TOP_W-1:0] trial;
    logic             fits;

    assign trial = {rem_q[k], lo_q[k][VEC_WIDTH-1]};
    assign fits  = trial >= TOP_W'(den_i);

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= fits ? DEN_W'(trial - TOP_W'(den_i)) : trial[DEN_W-1:0];
      quo_q[k+1] <= {quo_q[k][VEC_WIDTH-2:0], fits};
      sgn_q[k+1] <= sgn_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end

    if (k < VEC_WIDTH - 1) begin : g_lo
      always_ff @(posedge clk_i) begin
        lo_q[k+1] <= lo_q[k] << 1;
      end
    end
  end

  // ties go up, i.e. away from zero on the magnitude
  always_comb begin
    rnd       = {rem_q[VEC_WIDTH], 1'b0} >= TOP_W'(den_i);
    res_d.mag = MAG_W'(quo_q[VEC_WIDTH]) + MAG_W'(rnd);
    res_d.neg = sgn_q[VEC_WIDTH];
    res_d.ovf = ovf_q[VEC_WIDTH];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/qvr_merge.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate merge
// Clips each lane, restores the sign, gathers the flags into one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic               zero_i,
  input  qvr_pkg::lane_res_t lane_i [qvr_pkg::NUM_LANES],
  output logic               done_o,
  output qvr_pkg::vec_res_t  res_o
);
  import qvr_pkg::*;

  logic [MAG_W-1:0]     lim  [NUM_LANES];
  logic                 clip [NUM_LANES];
  logic [MAG_W-1:0]     val  [NUM_LANES];
  logic [MAG_W-1:0]     sval [NUM_LANES];
  logic                 sat_any;
  vec_res_t             res_d, res_q;
  logic                 done_q;

  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      lim[i]  = lane_i[i].neg ? HALF : HALF - MAG_W'(1);
      clip[i] = lane_i[i].ovf || (lane_i[i].mag > lim[i]);
      val[i]  = clip[i] ? lim[i] : lane_i[i].mag;
      sval[i] = lane_i[i].neg ? -val[i] : val[i];
      sat_any = sat_any | clip[i];
    end
  end

  // zero norm: divider output is meaningless, force zeros
  always_comb begin
    if (zero_i) begin
      res_d = '0;
      res_d.zero_norm = 1'b1;
    end else begin
      res_d.out_x     = sval[0][VEC_WIDTH-1:0];
      res_d.out_y     = sval[1][VEC_WIDTH-1:0];
      res_d.out_z     = sval[2][VEC_WIDTH-1:0];
      res_d.saturated = sat_any;
      res_d.zero_norm = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hw/rtl/quaternion_vector_rotate_top.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate
// Rotates a 3-D vector by a configured quaternion, one request per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_i when start is high and busy is low. busy stays
//   low: a new request can be issued every cycle, the pipeline keeps up to
//   32 requests in flight with no dependence between them.
//   Each result appears on res_o for exactly one cycle with done_o high
//   (32 register stages: front end 2, lane 29, merge 1).
//   The depth is set by the lane divider, which produces one quotient bit
//   per stage over the 24-bit range.
//   Results leave in request order; the receiver cannot stall the block.
//   The quaternion lives in four APB registers (w, x, y, z at 0x0..0xC);
//   pready is tied high. Write them only while no request is in flight.
//   The norm terms derived from them are registered in qvr_norm after a write.
//   Reset empties the pipeline and loads the identity quaternion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_top_defines.svh"

module quaternion_vector_rotate_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  qvr_pkg::vec_req_t              req_i,
  output logic                           done_o,
  output qvr_pkg::vec_res_t              res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qvr_pkg::ADDR_W-1:0]     paddr,
  input  logic [qvr_pkg::APB_DW-1:0]     pwdata,
  output logic [qvr_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import qvr_pkg::*;

  logic                        accept;
  logic                        cfg_we;
  reg_idx_e                    cfg_idx;
  quat_t                       quat_d, quat_q;
  logic [PIPE_LAT-1:0]         vld_d, vld_q;
  norm_t                       norm;
  logic signed [DOT_W-1:0]     dot2;
  logic signed [CRS_W-1:0]     crs  [NUM_LANES];
  logic signed [VEC_WIDTH-1:0] vec  [NUM_LANES];
  logic signed [QUAT_WIDTH-1:0] u   [NUM_LANES];
  lane_res_t                   lane_res [NUM_LANES];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // configuration registers
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    quat_d = quat_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUAT_W: quat_d.w = pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_X: quat_d.x = pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_Y: quat_d.y = pwdata[QUAT_WIDTH-1:0];
        REG_QUAT_Z: quat_d.z = pwdata[QUAT_WIDTH-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_QUAT_W: prdata = APB_DW'($unsigned(quat_q.w));
      REG_QUAT_X: prdata = APB_DW'($unsigned(quat_q.x));
      REG_QUAT_Y: prdata = APB_DW'($unsigned(quat_q.y));
      REG_QUAT_Z: prdata = APB_DW'($unsigned(quat_q.z));
    endcase
  end

  // request valid travels alongside the payload pipeline
  assign vld_d = {vld_q[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q <= QUAT_RST;
      vld_q  <= '0;
    end else begin
      quat_q <= quat_d;
      vld_q  <= vld_d;
    end
  end

  qvr_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .quat_i (quat_q),
    .norm_o (norm)
  );

  qvr_front u_front (
    .clk_i  (clk_i),
    .req_i  (req_i),
    .quat_i (quat_q),
    .dot2_o (dot2),
    .crs_o  (crs),
    .vec_o  (vec)
  );

  assign u[0] = quat_q.x;
  assign u[1] = quat_q.y;
  assign u[2] = quat_q.z;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    qvr_lane u_lane (
      .clk_i  (clk_i),
      .s_i    (norm.s),
      .den_i  (norm.den),
      .w_i    (quat_q.w),
      .u_i    (u[i]),
      .dot2_i (dot2),
      .crs_i  (crs[i]),
      .vec_i  (vec[i]),
      .res_o  (lane_res[i])
    );
  end

  qvr_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q[PIPE_LAT-1]),
    .zero_i (norm.zero),
    .lane_i (lane_res),
    .done_o (done_o),
    .res_o  (res_o)
  );

  `QVR_ASSERT(a_done_after_accept, clk_i, rst_ni, done_o |-> $past(accept, RES_LAT))
  `QVR_ASSERT(a_zero_norm_clean, clk_i, rst_ni,
    (done_o && res_o.zero_norm) |-> (res_o.out_x == '0 && res_o.out_y == '0 &&
    res_o.out_z == '0 && !res_o.saturated))
  `QVR_ASSERT(a_sat_at_limit, clk_i, rst_ni,
    (done_o && res_o.saturated) |-> (res_o.out_x == VEC_MAX || res_o.out_x == VEC_MIN ||
    res_o.out_y == VEC_MAX || res_o.out_y == VEC_MIN ||
    res_o.out_z == VEC_MAX || res_o.out_z == VEC_MIN))
  `QVR_ASSERT_NEVER(a_no_sat_on_zero_norm, clk_i, rst_ni,
    done_o && res_o.saturated && res_o.zero_norm)

endmodule

/* tb/sv/qvr_rotate_checker.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate checker
// Watches the request, result and register ports of the rotator. Keeps its
// own copy of the quaternion, predicts each rotated vector and compares
// results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_rotate_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  qvr_pkg::vec_req_t          req_i,
  input  logic                       done_i,
  input  qvr_pkg::vec_res_t          res_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [qvr_pkg::ADDR_W-1:0] paddr_i,
  input  logic [qvr_pkg::APB_DW-1:0] pwdata_i,
  input  logic [qvr_pkg::APB_DW-1:0] prdata_i,
  input  logic                       pready_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import qvr_pkg::*;

  localparam int MAX_PRINTS = 100;

  quat_t                 quat_q;
  vec_res_t              rotated_q[$];
  reg_idx_e              reg_idx;
  logic [QUAT_WIDTH-1:0] reg_val;
  int                    fails = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    if (fails < MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
    fails++;
  endtask

  // vector part of q v conj(q) / |q|^2; exact below 2^57, so 64 bits suffice
  function automatic vec_res_t rotate_vec(input quat_t q, input vec_req_t r);
    longint   w, x, y, z, vx, vy, vz, uu, den, s, dot2, w2, mag, qt, rem, lim;
    longint   num[3];
    longint   lane[3];
    logic     sat, neg;
    int       k;
    vec_res_t res;
    w  = q.w;
    x  = q.x;
    y  = q.y;
    z  = q.z;
    vx = r.vec_x;
    vy = r.vec_y;
    vz = r.vec_z;
    res = '0;
    if (r.func) begin
      x = -x;
      y = -y;
      z = -z;
    end
    uu  = x * x + y * y + z * z;
    den = w * w + uu;
    if (den == 0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    s    = w * w - uu;
    dot2 = 2 * (x * vx + y * vy + z * vz);
    w2   = 2 * w;
    num[0] = s * vx + dot2 * x + w2 * (y * vz - z * vy);
    num[1] = s * vy + dot2 * y + w2 * (z * vx - x * vz);
    num[2] = s * vz + dot2 * z + w2 * (x * vy - y * vx);
    sat = 1'b0;
    for (k = 0; k < 3; k++) begin
      neg = (num[k] < 0);
      mag = neg ? -num[k] : num[k];
      qt  = mag / den;
      rem = mag % den;
      // nearest, ties away from zero
      if (rem >= den - rem) qt = qt + 1;
      lim = longint'(1) << (VEC_WIDTH - 1);
      if (!neg) lim = lim - 1;
      if (qt > lim) begin
        sat = 1'b1;
        qt  = lim;
      end
      lane[k] = neg ? -qt : qt;
    end
    res.out_x     = VEC_WIDTH'(lane[0]);
    res.out_y     = VEC_WIDTH'(lane[1]);
    res.out_z     = VEC_WIDTH'(lane[2]);
    res.saturated = sat;
    return res;
  endfunction

  task automatic check_result(input vec_res_t got);
    vec_res_t want;
    if (rotated_q.size() == 0) begin
      report_mismatch("result with no request waiting");
    end else begin
      want = rotated_q.pop_front();
      if (got.out_x !== want.out_x)
        report_mismatch($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
      if (got.out_y !== want.out_y)
        report_mismatch($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
      if (got.out_z !== want.out_z)
        report_mismatch($sformatf("out_z got %0d want %0d", got.out_z, want.out_z));
      if (got.saturated !== want.saturated)
        report_mismatch($sformatf("saturated got %b want %b", got.saturated,
                                  want.saturated));
      if (got.zero_norm !== want.zero_norm)
        report_mismatch($sformatf("zero_norm got %b want %b", got.zero_norm,
                                  want.zero_norm));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quat_q = QUAT_RST;
      rotated_q.delete();
    end else begin
      // results come from older requests, so compare before queuing a new one
      if (done_i === 1'b1) check_result(res_i);
      if (start_i && !busy_i) rotated_q.push_back(rotate_vec(quat_q, req_i));
      if (psel_i && penable_i && pready_i) begin
        reg_idx = reg_idx_e'(paddr_i[ADDR_W-1:2]);
        if (pwrite_i) begin
          case (reg_idx)
            REG_QUAT_W: quat_q.w = pwdata_i[QUAT_WIDTH-1:0];
            REG_QUAT_X: quat_q.x = pwdata_i[QUAT_WIDTH-1:0];
            REG_QUAT_Y: quat_q.y = pwdata_i[QUAT_WIDTH-1:0];
            REG_QUAT_Z: quat_q.z = pwdata_i[QUAT_WIDTH-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx)
            REG_QUAT_W: reg_val = quat_q.w;
            REG_QUAT_X: reg_val = quat_q.x;
            REG_QUAT_Y: reg_val = quat_q.y;
            default:    reg_val = quat_q.z;
          endcase
          if (prdata_i[QUAT_WIDTH-1:0] !== reg_val)
            report_mismatch($sformatf("read of %s got %h want %h", reg_idx.name(),
                                      prdata_i[QUAT_WIDTH-1:0], reg_val));
        end
      end
    end
    pending_o = rotated_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Quaternion vector rotate testbench
// Loads a series of quaternions over APB (extremes, zero, small and random
// values), sends directed corner vectors and then random vectors with
// varying request gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import qvr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BATCHES        = 12;
  localparam int BATCH_ITEMS    = 160;

  localparam logic signed [QUAT_WIDTH-1:0] Q_MAX = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
  localparam logic signed [QUAT_WIDTH-1:0] Q_MIN = {1'b1, {(QUAT_WIDTH-1){1'b0}}};
  localparam logic signed [VEC_WIDTH-1:0]  V_P1  = VEC_WIDTH'(1);
  localparam logic signed [VEC_WIDTH-1:0]  V_M1  = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  vec_req_t          req;
  logic              done;
  vec_res_t          res;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                stall_cycles = 0;

  quaternion_vector_rotate_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .done_o  (done),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qvr_rotate_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .res_i        (res),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // counts cycles in which neither a request, a result nor a register access completes
  always @(posedge clk_i) begin
    if ((start && !busy) || done === 1'b1 || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL quaternion_vector_rotate_top");
      $finish;
    end
  end

  function automatic logic signed [VEC_WIDTH-1:0] rand_component();
    case ($urandom_range(9))
      0:       return VEC_MAX;
      1:       return VEC_MIN;
      2:       return '0;
      3:       return $urandom_range(1) ? V_P1 : V_M1;
      4, 5:    return VEC_WIDTH'(int'($urandom_range(512)) - 256);
      default: return VEC_WIDTH'($urandom());
    endcase
  endfunction

  function automatic vec_req_t rand_vector();
    vec_req_t r;
    r.func  = 1'($urandom_range(1));
    r.vec_x = rand_component();
    r.vec_y = rand_component();
    r.vec_z = rand_component();
    return r;
  endfunction

  function automatic logic signed [QUAT_WIDTH-1:0] rand_quat_part(input bit tiny);
    if (tiny) return QUAT_WIDTH'(int'($urandom_range(6)) - 3);
    return QUAT_WIDTH'($urandom());
  endfunction

  function automatic quat_t pick_quat(input int phase);
    quat_t q;
    bit    tiny;
    tiny = ($urandom_range(2) == 0);
    case (phase)
      0:       q = '{w: Q_MAX, x: Q_MAX, y: Q_MAX, z: Q_MAX};
      1:       q = '{w: Q_MIN, x: Q_MIN, y: Q_MIN, z: Q_MIN};
      2:       q = '0;
      3:       q = '{w: '0, x: Q_MIN, y: '0, z: '0};
      4:       q = '{w: Q_MAX, x: Q_MIN, y: '0, z: Q_MAX};
      default: q = '{w: rand_quat_part(tiny), x: rand_quat_part(tiny),
                     y: rand_quat_part(tiny), z: rand_quat_part(tiny)};
    endcase
    return q;
  endfunction

  // leaves psel/penable high; the next access lowers penable, load_quat lowers both
  task automatic apb_access(input bit wr, input reg_idx_e idx,
                            input logic [QUAT_WIDTH-1:0] val);
    logic [APB_DW-1:0] word;
    word                   = $urandom();
    word[QUAT_WIDTH-1:0]   = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic load_quat(input quat_t q);
    logic [QUAT_WIDTH-1:0] vals[4];
    int                    first;
    int                    k;
    vals[REG_QUAT_W] = q.w;
    vals[REG_QUAT_X] = q.x;
    vals[REG_QUAT_Y] = q.y;
    vals[REG_QUAT_Z] = q.z;
    first = $urandom_range(3);
    for (k = 0; k < 4; k++)
      apb_access(1'b1, reg_idx_e'((first + k) % 4), vals[(first + k) % 4]);
    for (k = 0; k < 4; k++)
      apb_access(1'b0, reg_idx_e'(k), '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    // norm terms follow the registers through the qvr_norm registers
    repeat (3) @(negedge clk_i);
  endtask

  task automatic issue_vector(input vec_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req   <= rand_vector();
      @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    vec_req_t item;
    int       m;
    int       p;
    int       n;
    int       idle_pct;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // identity quaternion straight out of reset
    item = '{func: 1'b0, vec_x: VEC_MAX, vec_y: VEC_MIN, vec_z: '0};
    issue_vector(item, 0);
    item = '{func: 1'b1, vec_x: VEC_MIN, vec_y: VEC_MAX, vec_z: V_P1};
    issue_vector(item, 0);
    item = '{func: 1'b0, vec_x: V_P1, vec_y: V_M1, vec_z: VEC_MAX};
    issue_vector(item, 0);

    // 45 degrees about z: corner vectors push the rotated lengths past full scale
    drain();
    load_quat('{w: QUAT_WIDTH'(15137), x: '0, y: '0, z: QUAT_WIDTH'(6270)});
    for (m = 0; m < 16; m++) begin
      item.func  = m[3];
      item.vec_x = m[0] ? VEC_MAX : VEC_MIN;
      item.vec_y = m[1] ? VEC_MAX : VEC_MIN;
      item.vec_z = m[2] ? VEC_MAX : VEC_MIN;
      issue_vector(item, 0);
    end
    for (m = 0; m < 2; m++) begin
      item = '{func: m[0], vec_x: V_P1, vec_y: V_M1, vec_z: V_P1};
      issue_vector(item, 0);
    end

    // zero quaternion: zero outputs with the norm fault raised
    drain();
    load_quat('0);
    for (m = 0; m < 2; m++) begin
      item = '{func: m[0], vec_x: VEC_MAX, vec_y: VEC_MIN, vec_z: V_M1};
      issue_vector(item, 0);
    end

    for (p = 0; p < BATCHES; p++) begin
      drain();
      load_quat(pick_quat(p));
      idle_pct = (p < 4) ? 35 : ((p < 8) ? 53 : 0);
      for (n = 0; n < BATCH_ITEMS; n++) issue_vector(rand_vector(), idle_pct);
    end

    drain();
    repeat (RES_LAT + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS quaternion_vector_rotate_top");
    end else begin
      $display("FAIL quaternion_vector_rotate_top");
    end
    $finish;
  end

endmodule
